### design/uft_pkg.sv
// shared types, phase/tag/error codes and scheme word tables for the url field tagger
// no dependencies; imported by uft_step, url_field_tagger_core and uft_checker
package uft_pkg;

  // parse phases
  localparam logic [3:0] PhScheme    = 4'd0;
  localparam logic [3:0] PhSlash1    = 4'd1;
  localparam logic [3:0] PhSlash2    = 4'd2;
  localparam logic [3:0] PhHost      = 4'd3;
  localparam logic [3:0] PhPort      = 4'd4;
  localparam logic [3:0] PhPath      = 4'd5;
  localparam logic [3:0] PhMisc      = 4'd6;
  localparam logic [3:0] PhErrScheme = 4'd7;
  localparam logic [3:0] PhErrFormat = 4'd8;

  // field tags
  localparam logic [2:0] TagScheme  = 3'd0;
  localparam logic [2:0] TagDelim   = 3'd1;
  localparam logic [2:0] TagHost    = 3'd2;
  localparam logic [2:0] TagPort    = 3'd3;
  localparam logic [2:0] TagPath    = 3'd4;
  localparam logic [2:0] TagMisc    = 3'd5;
  localparam logic [2:0] TagIgnored = 3'd6;

  // error codes
  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrScheme = 2'd1;
  localparam logic [1:0] ErrFormat = 2'd2;

  // characters of interest
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] CaseOffset   = 8'h20;
  localparam logic [7:0] PrintableLow = 8'h20;
  localparam logic [7:0] PrintableEnd = 8'h7f;

  localparam logic [2:0] MailtoLen = 3'd6;
  localparam logic [2:0] NewsLen   = 3'd4;
  localparam logic [2:0] LenMax    = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } uft_in_t;

  typedef struct packed {
    logic [2:0] field_tag;
    logic [7:0] out_char;
    logic       promote_user;
    logic [1:0] error_code;
  } uft_out_t;

  typedef struct packed {
    logic [3:0] parse_phase;
    logic       user_seen;
    logic [2:0] scheme_length;
    logic       mailto_match;
    logic       news_match;
  } uft_state_t;

  localparam uft_state_t StateRestart = '{
    parse_phase:   PhScheme,
    user_seen:     1'b0,
    scheme_length: 3'd0,
    mailto_match:  1'b1,
    news_match:    1'b1
  };

  function automatic logic [7:0] mailto_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6d;  // m
      3'd1:    c = 8'h61;  // a
      3'd2:    c = 8'h69;  // i
      3'd3:    c = 8'h6c;  // l
      3'd4:    c = 8'h74;  // t
      3'd5:    c = 8'h6f;  // o
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] news_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6e;  // n
      2'd1:    c = 8'h65;  // e
      2'd2:    c = 8'h77;  // w
      default: c = 8'h73;  // s
    endcase
    return c;
  endfunction

endpackage

### design/uft_step.sv
// per-byte parse decision: next parse state and the tagged result for one byte
// depends on uft_pkg
module uft_step (
  input  uft_pkg::uft_state_t state_i,
  input  uft_pkg::uft_in_t    in_i,
  output uft_pkg::uft_state_t state_o,
  output uft_pkg::uft_out_t   out_o
);
  import uft_pkg::*;

  uft_state_t st;
  uft_state_t nxt;
  logic [7:0] ch;
  logic [7:0] oc;
  logic [2:0] tag;
  logic       promote;
  logic [1:0] err;
  logic       is_upper;
  logic       is_scheme_ch;
  logic       is_printable;

  assign ch = in_i.ch;
  assign is_upper = (ch >= ChUpA) && (ch <= ChUpZ);
  assign is_scheme_ch = (ch inside {[ChLowA:ChLowZ], [ChUpA:ChUpZ], ChPlus, ChDot, ChMinus});
  assign is_printable = (ch >= PrintableLow) && (ch < PrintableEnd);

  always_comb begin
    // a first byte sees the restart state, not what the last url left
    st      = in_i.first ? StateRestart : state_i;
    nxt     = st;
    tag     = TagIgnored;
    oc      = ch;
    promote = 1'b0;
    err     = ErrNone;

    case (st.parse_phase)
      PhScheme: begin
        if (ch == ChColon) begin
          tag = TagDelim;
          if ((st.mailto_match && st.scheme_length == MailtoLen) ||
              (st.news_match && st.scheme_length == NewsLen)) begin
            nxt.parse_phase = PhMisc;
          end else begin
            nxt.parse_phase = PhSlash1;
          end
        end else if (is_scheme_ch) begin
          if (is_upper) begin
            oc = ch + CaseOffset;
          end
          tag = TagScheme;
          if (!(st.scheme_length < MailtoLen && oc == mailto_char(st.scheme_length))) begin
            nxt.mailto_match = 1'b0;
          end
          if (!(st.scheme_length < NewsLen && oc == news_char(st.scheme_length[1:0]))) begin
            nxt.news_match = 1'b0;
          end
          if (st.scheme_length < LenMax) begin
            nxt.scheme_length = st.scheme_length + 3'd1;
          end
        end else begin
          nxt.parse_phase = PhErrScheme;
        end
      end
      PhSlash1, PhSlash2: begin
        if (ch == ChSlash) begin
          tag = TagDelim;
          nxt.parse_phase = (st.parse_phase == PhSlash1) ? PhSlash2 : PhHost;
        end else begin
          nxt.parse_phase = PhErrFormat;
        end
      end
      PhHost, PhPort: begin
        if (ch == ChColon && st.parse_phase == PhHost) begin
          tag = TagDelim;
          nxt.parse_phase = PhPort;
        end else if (ch == ChSlash) begin
          tag = TagPath;
          nxt.parse_phase = PhPath;
        end else if (ch == ChAt) begin
          // a second '@' is a format error
          if (st.user_seen) begin
            nxt.parse_phase = PhErrFormat;
          end else begin
            nxt.user_seen   = 1'b1;
            tag             = TagDelim;
            promote         = 1'b1;
            nxt.parse_phase = PhHost;
          end
        end else if (is_printable) begin
          tag = (st.parse_phase == PhHost) ? TagHost : TagPort;
        end else begin
          nxt.parse_phase = PhErrFormat;
        end
      end
      PhPath:      tag = TagPath;
      PhMisc:      tag = TagMisc;
      PhErrScheme: tag = TagIgnored;
      default:     nxt.parse_phase = PhErrFormat;
    endcase

    if (nxt.parse_phase == PhErrScheme) begin
      tag = TagIgnored;
      err = ErrScheme;
    end else if (nxt.parse_phase == PhErrFormat) begin
      tag = TagIgnored;
      err = ErrFormat;
    end
  end

  assign state_o = nxt;
  assign out_o   = '{field_tag: tag, out_char: oc, promote_user: promote, error_code: err};

endmodule

### design/url_field_tagger_core.sv
// top level of the url field tagger: parse state, output register and handshake
// depends on uft_pkg and uft_step
//
// The block takes one url byte per request and returns one tagged byte per request,
// in order. The parse decision for a byte is a single pass through uft_step
// between the parse state register and the result register, so a new byte is
// accepted every cycle while the result side keeps taking them.
// in_ready_o is high whenever the result register is empty or being emptied in the
// same cycle. Set first on the opening byte of each url to restart parsing.
module url_field_tagger_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  uft_pkg::uft_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output uft_pkg::uft_out_t out_data_o
);
  import uft_pkg::*;

  uft_state_t state_q, state_d;
  uft_out_t   res_q, res_d;
  logic       out_valid_q;
  logic       in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  uft_step u_step (
    .state_i (state_q),
    .in_i    (in_data_i),
    .state_o (state_d),
    .out_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRestart;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

### design/uft_checker.sv
// port-level checks for url_field_tagger_core, attached by the bind below
// depends on uft_pkg
module uft_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input uft_pkg::uft_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input uft_pkg::uft_out_t out_data_o
);
  import uft_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // ignored tag goes together with an error code
  a_err_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.field_tag == TagIgnored) == (out_data_o.error_code != ErrNone)))
    else $error("error code and ignored tag disagree");

  // promotion only on a clean delimiter
  a_promote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.promote_user |->
      out_data_o.field_tag == TagDelim && out_data_o.out_char == ChAt)
    else $error("promote_user on something other than an accepted at sign");

  // an accepted request always yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // a scheme-error result is followed by scheme errors until a first byte
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.error_code == ErrScheme &&
      in_valid_i && in_ready_o && !in_data_i.first |=>
      out_data_o.error_code == ErrScheme)
    else $error("scheme error not sticky");

endmodule

bind url_field_tagger_core uft_checker u_uft_checker (.*);

### bench/tb_url_field_tagger_core.sv
// self-checking bench for url_field_tagger_core: directed table, then random url streams
// depends on uft_pkg and the url_field_tagger_core rtl; a local byte tagger predicts results
module tb_url_field_tagger_core;
  import uft_pkg::*;

  localparam int ItemsTarget  = 1750;
  localparam int WatchdogMax  = 2000;
  localparam int HoldCycles   = 300;
  localparam int HoldAfter    = 1300;
  localparam int SettleCycles = 4;

  localparam logic [47:0] MailtoWord = "mailto";
  localparam logic [31:0] NewsWord   = "news";

  typedef struct {
    uft_in_t  req;
    bit       typed;
    uft_out_t want;
  } stim_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  uft_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  uft_out_t out_data_o;

  uft_state_t tagger_st = StateRestart;
  uft_out_t   expected_tags[$];
  stim_row_t  stim_rows[$];
  logic [7:0] url_q[$];

  int sent_count    = 0;
  int fail_count    = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 82;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  url_field_tagger_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // tags one byte and advances the local parse state
  function automatic uft_out_t tag_byte(input uft_in_t r);
    uft_out_t   res;
    logic [7:0] c;
    logic [7:0] lc;
    int         len;
    c = r.ch;
    res.field_tag    = TagIgnored;
    res.out_char     = c;
    res.promote_user = 1'b0;
    res.error_code   = ErrNone;
    if (r.first) tagger_st = StateRestart;
    len = tagger_st.scheme_length;
    case (tagger_st.parse_phase)
      PhScheme: begin
        if (c == ChColon) begin
          res.field_tag = TagDelim;
          if (tagger_st.mailto_match && len == 6) tagger_st.parse_phase = PhMisc;
          else if (tagger_st.news_match && len == 4) tagger_st.parse_phase = PhMisc;
          else tagger_st.parse_phase = PhSlash1;
        end else if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) ||
                     c == ChPlus || c == ChDot || c == ChMinus) begin
          lc = (c >= ChUpA && c <= ChUpZ) ? c + CaseOffset : c;
          res.out_char  = lc;
          res.field_tag = TagScheme;
          if (!(len < 6 && lc == MailtoWord[8*(5-len) +: 8])) tagger_st.mailto_match = 1'b0;
          if (!(len < 4 && lc == NewsWord[8*(3-len) +: 8])) tagger_st.news_match = 1'b0;
          if (len < 7) tagger_st.scheme_length = tagger_st.scheme_length + 3'd1;
        end else begin
          tagger_st.parse_phase = PhErrScheme;
        end
      end
      PhSlash1, PhSlash2: begin
        if (c == ChSlash) begin
          res.field_tag = TagDelim;
          tagger_st.parse_phase = (tagger_st.parse_phase == PhSlash1) ? PhSlash2 : PhHost;
        end else begin
          tagger_st.parse_phase = PhErrFormat;
        end
      end
      PhHost, PhPort: begin
        if (c == ChColon && tagger_st.parse_phase == PhHost) begin
          res.field_tag = TagDelim;
          tagger_st.parse_phase = PhPort;
        end else if (c == ChSlash) begin
          res.field_tag = TagPath;
          tagger_st.parse_phase = PhPath;
        end else if (c == ChAt) begin
          if (tagger_st.user_seen) begin
            tagger_st.parse_phase = PhErrFormat;
          end else begin
            tagger_st.user_seen   = 1'b1;
            res.field_tag         = TagDelim;
            res.promote_user      = 1'b1;
            tagger_st.parse_phase = PhHost;
          end
        end else if (c >= PrintableLow && c < PrintableEnd) begin
          res.field_tag = (tagger_st.parse_phase == PhHost) ? TagHost : TagPort;
        end else begin
          tagger_st.parse_phase = PhErrFormat;
        end
      end
      PhPath:      res.field_tag = TagPath;
      PhMisc:      res.field_tag = TagMisc;
      PhErrScheme: ;
      default:     tagger_st.parse_phase = PhErrFormat;
    endcase
    if (tagger_st.parse_phase == PhErrScheme) begin
      res.field_tag  = TagIgnored;
      res.error_code = ErrScheme;
    end else if (tagger_st.parse_phase == PhErrFormat) begin
      res.field_tag  = TagIgnored;
      res.error_code = ErrFormat;
    end
    return res;
  endfunction

  task automatic stim_row(input logic [7:0] ch, input logic first, input bit typed,
                          input logic [2:0] tag, input logic [7:0] oc, input logic prom,
                          input logic [1:0] err);
    stim_row_t row;
    row.req.ch            = ch;
    row.req.first         = first;
    row.typed             = typed;
    row.want.field_tag    = tag;
    row.want.out_char     = oc;
    row.want.promote_user = prom;
    row.want.error_code   = err;
    stim_rows.push_back(row);
  endtask

  // offers one request, waits for it to be taken and records what should come back
  task automatic push_byte(input uft_in_t r, input bit typed, input uft_out_t want);
    uft_out_t guess;
    if (sent_count < 600) begin
      send_idle_pct = 24;
      recv_idle_pct = 82;
    end else if (sent_count < 1200) begin
      send_idle_pct = 82;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = tag_byte(r);
    expected_tags.push_back(typed ? want : guess);
    sent_count++;
  endtask

  function automatic logic [7:0] host_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7e));
    if (c == ChColon || c == ChSlash || c == ChAt) c = "h";
    return c;
  endfunction

  // builds one url in url_q: mostly well formed, some noise or a corrupted byte
  task automatic make_url(output bit noisy);
    int          kind, n, i, r, wlen, seg;
    logic [7:0]  c;
    logic [47:0] word;
    url_q.delete();
    kind  = $urandom_range(0, 15);
    noisy = (kind >= 14);
    if (noisy) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) url_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 4) begin
        if (kind < 2) begin
          word = MailtoWord;
          wlen = 6;
        end else begin
          word = {16'h0, NewsWord};
          wlen = 4;
        end
        // now and then one letter short or one too many
        n = wlen;
        if ($urandom_range(0, 5) == 0) n = wlen - 1 + 2 * $urandom_range(0, 1);
        for (i = 0; i < n; i++) begin
          c = (i < wlen) ? word[8*(wlen-1-i) +: 8] : "s";
          if ($urandom_range(0, 1)) c = c - CaseOffset;
          url_q.push_back(c);
        end
      end else begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          r = $urandom_range(0, 54);
          if (r < 26) c = ChLowA + 8'(r);
          else if (r < 52) c = ChUpA + 8'(r - 26);
          else if (r == 52) c = ChPlus;
          else if (r == 53) c = ChDot;
          else c = ChMinus;
          url_q.push_back(c);
        end
      end
      url_q.push_back(ChColon);
      if (kind < 4) begin
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) url_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        url_q.push_back(ChSlash);
        url_q.push_back(ChSlash);
        // user:password@host:port, the user part optional, rarely a second '@'
        for (seg = 0; seg < 2; seg++) begin
          n = $urandom_range(0, 6);
          for (i = 0; i < n; i++) url_q.push_back(host_char());
          if ($urandom_range(0, 1)) begin
            url_q.push_back(ChColon);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
              url_q.push_back($urandom_range(0, 3) != 0 ? 8'h30 + 8'($urandom_range(0, 9))
                                                        : host_char());
          end
          if (seg == 0 && $urandom_range(0, 2) != 0) seg = 1;
          else if (seg == 0) url_q.push_back(ChAt);
          else if ($urandom_range(0, 9) == 0) url_q.push_back(ChAt);
        end
        if ($urandom_range(0, 3) != 0) begin
          url_q.push_back(ChSlash);
          n = $urandom_range(0, 10);
          for (i = 0; i < n; i++) url_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 7) == 0)
        url_q[$urandom_range(0, url_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic report_result(input string what, input uft_out_t want, input uft_out_t got);
    if (fail_count < 10)
      $display({"%s: expected tag %0d char %h promote %0d err %0d,",
                " got tag %0d char %h promote %0d err %0d"},
               what, want.field_tag, want.out_char, want.promote_user, want.error_code,
               got.field_tag, got.out_char, got.promote_user, got.error_code);
    fail_count++;
  endtask

  // result side: check, then pick ready for the next cycle
  initial begin
    uft_out_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_tags.size() == 0) begin
          report_result("result with no request pending", '0, out_data_o);
        end else begin
          want = expected_tags.pop_front();
          if (out_data_o.field_tag !== want.field_tag || out_data_o.out_char !== want.out_char ||
              out_data_o.promote_user !== want.promote_user ||
              out_data_o.error_code !== want.error_code)
            report_result("mismatch", want, out_data_o);
        end
      end
      // one long hold-off so that the core fills and stalls its input
      if (!hold_done && sent_count >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogMax) begin
        $display("watchdog: no progress for %0d cycles", WatchdogMax);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    uft_in_t  req;
    bit       noisy;
    int       i;
    // mailto, folded case, then misc takes any byte
    stim_row("M",   1'b1, 1'b1, TagScheme,  "m",   1'b0, ErrNone);
    stim_row("a",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("i",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("l",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("t",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("O",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row(":",   1'b0, 1'b1, TagDelim,   ":",   1'b0, ErrNone);
    stim_row(8'h00, 1'b0, 1'b1, TagMisc,    8'h00, 1'b0, ErrNone);
    stim_row(8'hff, 1'b0, 1'b1, TagMisc,    8'hff, 1'b0, ErrNone);
    // user, colon inside the port, then a second '@'
    stim_row("h",   1'b1, 1'b0, '0, '0, '0, '0);
    stim_row("+",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row(":",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("/",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("/",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("u",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("@",   1'b0, 1'b1, TagDelim,   "@",   1'b1, ErrNone);
    stim_row(":",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row(":",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("@",   1'b0, 1'b1, TagIgnored, "@",   1'b0, ErrFormat);
    stim_row("/",   1'b0, 1'b1, TagIgnored, "/",   1'b0, ErrFormat);
    // byte zero as the first scheme byte, error stays until the next first byte
    stim_row(8'h00, 1'b1, 1'b1, TagIgnored, 8'h00, 1'b0, ErrScheme);
    stim_row("z",   1'b0, 1'b1, TagIgnored, "z",   1'b0, ErrScheme);
    // empty host, the path slash and a non-printable byte in the path
    stim_row("n",   1'b1, 1'b0, '0, '0, '0, '0);
    stim_row(":",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("/",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("/",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row("/",   1'b0, 1'b0, '0, '0, '0, '0);
    stim_row(8'h7f, 1'b0, 1'b0, '0, '0, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[k]) push_byte(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].want);

    while (sent_count < ItemsTarget) begin
      make_url(noisy);
      for (i = 0; i < url_q.size(); i++) begin
        req.ch = url_q[i];
        if (noisy)
          req.first = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
        else req.first = (i == 0);
        push_byte(req, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_tags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
